// File: rtl/mmc_pkg.sv
`default_nettype none

package mmc_pkg;

  // Sample field width on the ports and bits of it that are significant
  localparam int IN_W        = 16;
  localparam int SAMPLE_BITS = 16;

  // Tracker width: wide enough for the samples and for the +/-16000 uT reset values
  localparam int TRK_W = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
  localparam int RNG_W = TRK_W;
  localparam int TOT_W = TRK_W + 2;
  localparam int DIV_W = TRK_W + 2;

  localparam int OFF_W      = 16;
  localparam int SCALE_W    = 16;
  localparam int SCALE_FRAC = 14;
  localparam int NUM_SH     = SCALE_W - SCALE_FRAC;

  localparam int REQ_W   = 16;
  localparam int PROG_W  = 7;
  localparam int PNUM_W  = REQ_W + PROG_W;
  localparam int CNT_W   = $clog2(SCALE_W + 1);

  localparam logic signed [TRK_W-1:0] TRK_MIN_RST = TRK_W'(16000);
  localparam logic signed [TRK_W-1:0] TRK_MAX_RST = -TRK_W'(16000);

  localparam logic [REQ_W-1:0]   REQ_RESET  = REQ_W'(500);
  localparam logic [REQ_W-1:0]   COUNT_MAX  = '1;
  localparam logic [PROG_W-1:0]  PROG_FULL  = PROG_W'(100);
  localparam logic [SCALE_W-1:0] SCALE_ONE  = SCALE_W'(16384);
  localparam logic [SCALE_W-1:0] SCALE_MAX  = '1;

  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SUM,
    ST_DIV,
    ST_LOAD
  } mmc_state_e;

  typedef struct packed {
    logic clr;   // rearm trackers
    logic upd;   // fold sample into trackers
    logic prep;  // latch offset and range
    logic init;  // start scale division
    logic step;  // one quotient bit
    logic last;  // final quotient bit
  } lane_ctl_t;

  typedef struct packed {
    logic              accepted;
    logic              running;
    logic              done;
    logic              sat;
    logic [PROG_W-1:0] progress;
  } mmc_stat_t;

  // Keep the low SAMPLE_BITS bits, sign-extended to the tracker width
  function automatic logic signed [TRK_W-1:0] sext_sample(input logic [IN_W-1:0] v);
    logic [31:0]      vx;
    logic [TRK_W-1:0] r;
    vx = 32'(v);
    for (int i = 0; i < TRK_W; i++) begin
      if (i < SAMPLE_BITS) begin
        r[i] = vx[i];
      end else begin
        r[i] = vx[SAMPLE_BITS-1];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/mag_minmax_hard_soft_iron_calib_top.sv
// Each input passes through IDLE (accept), PREP, SUM, DIV and LOAD; the DIV
// state of the sample that completes a run also drives the three lane
// dividers, 16 quotient steps each, beside the 7-step progress divider. A new
// input is taken only in IDLE, and LOAD waits until the output register is free.
// Reset (rst_ni low, asynchronous): idle, run length 500, offsets 0,
// scales 1.0, trackers at +/-16000 uT, no result pending.
`default_nettype none

module mag_minmax_hard_soft_iron_calib_top import mmc_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [REQ_W-1:0]     cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 cmd_i,
  input  wire logic [IN_W-1:0]      sample_x_i,
  input  wire logic [IN_W-1:0]      sample_y_i,
  input  wire logic [IN_W-1:0]      sample_z_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic                      accepted_o,
  output logic                      running_o,
  output logic      [PROG_W-1:0]    progress_o,
  output logic                      done_res_o,
  output logic      [OFF_W-1:0]     bias_x_o,
  output logic      [OFF_W-1:0]     bias_y_o,
  output logic      [OFF_W-1:0]     bias_z_o,
  output logic      [SCALE_W-1:0]   scale_x_o,
  output logic      [SCALE_W-1:0]   scale_y_o,
  output logic      [SCALE_W-1:0]   scale_z_o,
  output logic                      scale_saturated_o
);

  lane_ctl_t              lane_ctl;
  mmc_stat_t              stat;
  logic [TOT_W-1:0]       total;
  logic [2:0][RNG_W-1:0]  range;
  logic [2:0][OFF_W-1:0]  offset;
  logic [2:0][SCALE_W-1:0] scale;
  logic [2:0]             sat;
  logic [2:0][IN_W-1:0]   sample;
  logic                   load, out_free, out_valid_q;

  mmc_stat_t               stat_q;
  logic [2:0][OFF_W-1:0]   offset_q;
  logic [2:0][SCALE_W-1:0] scale_q;

  assign sample   = {sample_z_i, sample_y_i, sample_x_i};
  assign out_free = !out_valid_q || out_ready_i;

  mmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .out_free_i (out_free),
    .range_i    (range),
    .sat_i      (sat),
    .in_ready_o (in_ready_o),
    .lane_ctl_o (lane_ctl),
    .total_o    (total),
    .load_o     (load),
    .stat_o     (stat)
  );

  for (genvar g = 0; g < 3; g++) begin : g_lane
    mmc_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (lane_ctl),
      .sample_i (sample[g]),
      .total_i  (total),
      .range_o  (range[g]),
      .offset_o (offset[g]),
      .scale_o  (scale[g]),
      .sat_o    (sat[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      stat_q   <= stat;
      offset_q <= offset;
      scale_q  <= scale;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign accepted_o        = stat_q.accepted;
  assign running_o         = stat_q.running;
  assign progress_o        = stat_q.progress;
  assign done_res_o        = stat_q.done;
  assign scale_saturated_o = stat_q.sat;
  assign bias_x_o          = offset_q[0];
  assign bias_y_o          = offset_q[1];
  assign bias_z_o          = offset_q[2];
  assign scale_x_o         = scale_q[0];
  assign scale_y_o         = scale_q[1];
  assign scale_z_o         = scale_q[2];

endmodule

`default_nettype wire

// File: rtl/mmc_lane.sv
`default_nettype none

module mmc_lane import mmc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire lane_ctl_t          ctl_i,
  input  wire logic [IN_W-1:0]    sample_i,
  input  wire logic [TOT_W-1:0]   total_i,
  output logic      [RNG_W-1:0]   range_o,
  output logic      [OFF_W-1:0]   offset_o,
  output logic      [SCALE_W-1:0] scale_o,
  output logic                    sat_o
);

  logic signed [TRK_W-1:0] min_q, min_d, max_q, max_d, smp;
  logic signed [TRK_W:0]   sum, sum_sh, diff;
  logic [RNG_W-1:0]        range_q;
  logic [DIV_W-1:0]        d_q, rem_q;
  logic [DIV_W+1:0]        twelve_r;
  logic [DIV_W:0]          rem2;
  logic                    ge;
  logic [SCALE_W-1:0]      num_q, quo_q, quo_nx;
  logic [OFF_W-1:0]        offset_q;
  logic [SCALE_W-1:0]      scale_q;
  logic                    sat_q, run_q;

  assign smp = sext_sample(sample_i);

  always_comb begin
    min_d = min_q;
    max_d = max_q;
    if (ctl_i.clr) begin
      min_d = TRK_MIN_RST;
      max_d = TRK_MAX_RST;
    end else if (ctl_i.upd) begin
      if (smp < min_q) min_d = smp;
      if (smp > max_q) max_d = smp;
    end
  end

  assign sum      = {max_q[TRK_W-1], max_q} + {min_q[TRK_W-1], min_q};
  assign sum_sh   = sum >>> 1;
  assign diff     = {max_q[TRK_W-1], max_q} - {min_q[TRK_W-1], min_q};
  assign twelve_r = {d_q, 2'b00};

  // restoring division: one quotient bit per step
  assign rem2   = {rem_q, num_q[SCALE_W-1]};
  assign ge     = rem2 >= {1'b0, d_q};
  assign quo_nx = {quo_q[SCALE_W-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q    <= TRK_MIN_RST;
      max_q    <= TRK_MAX_RST;
      offset_q <= '0;
      scale_q  <= SCALE_ONE;
      sat_q    <= 1'b0;
      run_q    <= 1'b0;
    end else begin
      min_q <= min_d;
      max_q <= max_d;
      if (ctl_i.prep) begin
        offset_q <= sum_sh[OFF_W-1:0];
      end
      if (ctl_i.init) begin
        // quotient above full scale exactly when total >= 12 * range
        if (range_q == '0 || {2'b00, total_i} >= twelve_r) begin
          scale_q <= SCALE_MAX;
          sat_q   <= 1'b1;
          run_q   <= 1'b0;
        end else begin
          sat_q   <= 1'b0;
          run_q   <= 1'b1;
        end
      end else if (ctl_i.step && run_q && ctl_i.last) begin
        scale_q <= quo_nx;
        run_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.prep) begin
      range_q <= (max_q > min_q) ? diff[RNG_W-1:0] : '0;
      d_q     <= (max_q > min_q) ?
                 ({2'b00, diff[RNG_W-1:0]} + {1'b0, diff[RNG_W-1:0], 1'b0}) : '0;
    end
    if (ctl_i.init) begin
      rem_q <= DIV_W'(total_i >> NUM_SH);
      num_q <= {total_i[NUM_SH-1:0], {SCALE_FRAC{1'b0}}};
    end else if (ctl_i.step) begin
      rem_q <= ge ? DIV_W'(rem2 - {1'b0, d_q}) : rem2[DIV_W-1:0];
      num_q <= {num_q[SCALE_W-2:0], 1'b0};
      quo_q <= quo_nx;
    end
  end

  assign range_o  = range_q;
  assign offset_o = offset_q;
  assign scale_o  = scale_q;
  assign sat_o    = sat_q;

endmodule

`default_nettype wire

// File: rtl/mmc_ctrl.sv
`default_nettype none

module mmc_ctrl import mmc_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic                  cmd_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [REQ_W-1:0]      cfg_data_i,
  input  wire logic                  out_free_i,
  input  wire logic [2:0][RNG_W-1:0] range_i,
  input  wire logic [2:0]            sat_i,
  output logic                       in_ready_o,
  output lane_ctl_t                  lane_ctl_o,
  output logic      [TOT_W-1:0]      total_o,
  output logic                       load_o,
  output mmc_stat_t                  stat_o
);

  mmc_state_e        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d, div_last;
  logic [REQ_W-1:0]  req_q, req_eff, count_q, count_inc;
  logic              busy_q, fin_q, acc_q, done_q, held_sat_q;
  logic              accept, do_start, do_sample, fin_now;
  logic [PNUM_W-1:0] pnum_q;
  logic [REQ_W-1:0]  prem_q;
  logic [REQ_W:0]    prem2;
  logic              pge;
  logic [PROG_W-1:0] plow_q, pquo_q;
  logic              pfull_q;
  logic [TOT_W-1:0]  total_q;

  assign req_eff   = (req_q == '0) ? REQ_W'(1) : req_q;
  assign accept    = (state_q == ST_IDLE) && in_valid_i;
  assign do_start  = (cmd_i == CMD_START) && !busy_q;
  assign do_sample = (cmd_i == CMD_SAMPLE) && busy_q;
  assign count_inc = (count_q == COUNT_MAX) ? count_q : count_q + REQ_W'(1);
  assign fin_now   = do_sample && (count_inc >= req_eff);
  assign div_last  = fin_q ? CNT_W'(SCALE_W) : CNT_W'(PROG_W - 1);

  assign prem2 = {prem_q, plow_q[PROG_W-1]};
  assign pge   = prem2 >= {1'b0, req_eff};

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    load_o     = 1'b0;
    lane_ctl_o = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          lane_ctl_o.clr = do_start;
          lane_ctl_o.upd = do_sample;
          state_d        = ST_PREP;
        end
      end
      ST_PREP: begin
        lane_ctl_o.prep = fin_q;
        state_d         = ST_SUM;
      end
      ST_SUM: begin
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        lane_ctl_o.init = fin_q && (cnt_q == '0);
        lane_ctl_o.step = fin_q && (cnt_q != '0);
        lane_ctl_o.last = cnt_q == CNT_W'(SCALE_W);
        if (cnt_q == div_last) begin
          state_d = ST_LOAD;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_LOAD: begin
        load_o = out_free_i;
        if (out_free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      req_q      <= REQ_RESET;
      count_q    <= '0;
      busy_q     <= 1'b0;
      fin_q      <= 1'b0;
      acc_q      <= 1'b0;
      done_q     <= 1'b0;
      held_sat_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) req_q <= cfg_data_i;
      if (accept) begin
        acc_q  <= do_start || do_sample;
        done_q <= fin_now;
        fin_q  <= fin_now;
        if (do_start) begin
          busy_q  <= 1'b1;
          count_q <= '0;
        end else if (do_sample) begin
          busy_q  <= !fin_now;
          count_q <= count_inc;
        end
      end
      // merge: any lane that saturated sets the held flag
      if (state_q == ST_DIV && fin_q && cnt_q == div_last) begin
        held_sat_q <= |sat_i;
      end
    end
  end

  // progress = count*100/required, restoring division over PROG_W steps
  always_ff @(posedge clk_i) begin
    if (state_q == ST_PREP) begin
      pnum_q  <= PNUM_W'(count_q) * PNUM_W'(100);
      pfull_q <= count_q >= req_eff;
    end
    if (state_q == ST_SUM) begin
      prem_q  <= pnum_q[PNUM_W-1:PROG_W];
      plow_q  <= pnum_q[PROG_W-1:0];
      total_q <= TOT_W'(range_i[0]) + TOT_W'(range_i[1]) + TOT_W'(range_i[2]);
    end
    if (state_q == ST_DIV && cnt_q < CNT_W'(PROG_W)) begin
      prem_q <= pge ? REQ_W'(prem2 - {1'b0, req_eff}) : prem2[REQ_W-1:0];
      plow_q <= {plow_q[PROG_W-2:0], 1'b0};
      pquo_q <= {pquo_q[PROG_W-2:0], pge};
    end
  end

  assign total_o         = total_q;
  assign stat_o.accepted = acc_q;
  assign stat_o.running  = busy_q;
  assign stat_o.done     = done_q;
  assign stat_o.sat      = held_sat_q;
  assign stat_o.progress = pfull_q ? PROG_FULL : pquo_q;

endmodule

`default_nettype wire
